### src/lrufro_pkg.sv
// ----------------------------------------------------------------------------
// lrufro_pkg: shared types for the LRU frame replacement order block
// Holds the command codes, controller states and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package lrufro_pkg;

  localparam int FIELD_W = 7;

  // request command codes
  localparam logic CMD_TOUCH  = 1'b0;
  localparam logic CMD_VICTIM = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK,
    ST_FRONT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;  // write one entry of the reset pattern
    logic accept;      // latch request, issue link reads
    logic link_step;   // unlink target from its neighbours
    logic front_step;  // link target in front of the head
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;  // final entry of the reset pattern
    logic skip;        // request leaves the order unchanged
    logic is_victim;   // latched request is a victim request
    logic out_free;    // output register can take a result
  } dp_status_t;

endpackage

### src/lrufro_ram.sv
// ----------------------------------------------------------------------------
// lrufro_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lrufro_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/lrufro_ctrl.sv
// ----------------------------------------------------------------------------
// lrufro_ctrl: sequencing controller
// Runs the clearing pass after reset, then steps each order-changing request
// through accept, unlink and move-to-front; other requests end at accept.
// ----------------------------------------------------------------------------
module lrufro_ctrl
  import lrufro_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (!st.skip) begin
            state_next = ST_LINK;
          end
        end
      end
      ST_LINK: begin
        cmd.link_step = 1'b1;
        state_next    = ST_FRONT;
      end
      ST_FRONT: begin
        // a victim waits here until the output register is free
        if (!st.is_victim || st.out_free) begin
          cmd.front_step = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

### src/lrufro_dp.sv
// ----------------------------------------------------------------------------
// lrufro_dp: link store datapath
// Next and previous link RAMs, head and tail registers, target latch and
// the result register.
// ----------------------------------------------------------------------------
module lrufro_dp
  import lrufro_pkg::*;
#(
  parameter int FRAMES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         st,
  input  logic               command,
  input  logic [FIELD_W-1:0] frame_index,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [FIELD_W-1:0] victim_frame
);

  localparam int LW = $clog2(FRAMES);
  localparam logic [LW-1:0] LAST = LW'(FRAMES - 1);

  logic [LW-1:0] head, tail, tgt, clr_idx;
  logic          vic;
  logic          out_valid;
  logic [FIELD_W-1:0] out_frame;

  logic [LW-1:0] tgt_in;
  logic          in_range;

  logic          nx_we, pv_we;
  logic [LW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata;
  logic [LW-1:0] nx_rdata, pv_rdata;
  logic          at_tail;

  // victim requests always act on the tail
  assign tgt_in   = (command == CMD_VICTIM) ? tail : LW'(frame_index);
  assign in_range = 32'(frame_index) < FRAMES;
  assign at_tail  = (tgt == tail);

  assign st.clear_last = (clr_idx == LAST);
  assign st.skip       = (command == CMD_TOUCH) && (!in_range || tgt_in == head);
  assign st.is_victim  = vic;
  assign st.out_free   = !out_valid || m_tready;

  assign m_tvalid     = out_valid;
  assign victim_frame = out_frame;

  // write port selection; pv_rdata is the predecessor, nx_rdata the successor
  always_comb begin
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    nx_waddr = tgt;
    nx_wdata = head;
    pv_waddr = head;
    pv_wdata = tgt;
    priority if (cmd.clear_step) begin
      nx_we    = 1'b1;
      pv_we    = 1'b1;
      nx_waddr = clr_idx;
      pv_waddr = clr_idx;
      nx_wdata = (clr_idx == LAST) ? '0 : LW'(clr_idx + 1'b1);
      pv_wdata = (clr_idx == '0) ? LAST : LW'(clr_idx - 1'b1);
    end else if (cmd.link_step) begin
      nx_we    = !at_tail;
      pv_we    = !at_tail;
      nx_waddr = pv_rdata;
      nx_wdata = nx_rdata;
      pv_waddr = nx_rdata;
      pv_wdata = pv_rdata;
    end else if (cmd.front_step) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
    end else begin
      nx_we = 1'b0;
    end
  end

  lrufro_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (tgt_in),
    .rdata (nx_rdata)
  );

  lrufro_ram #(.WIDTH(LW), .DEPTH(FRAMES)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (tgt_in),
    .rdata (pv_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= LAST;
      clr_idx   <= '0;
      vic       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step && clr_idx != LAST) begin
        clr_idx <= LW'(clr_idx + 1'b1);
      end
      if (cmd.accept) begin
        vic <= (command == CMD_VICTIM);
      end
      if (cmd.link_step && at_tail) begin
        tail <= pv_rdata;
      end
      if (cmd.front_step) begin
        head <= tgt;
      end
      if (cmd.front_step && vic) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tgt <= tgt_in;
    end
    if (cmd.front_step && vic) begin
      out_frame <= FIELD_W'(tgt);
    end
  end

endmodule

### src/lru_frame_replacement_order.sv
// ----------------------------------------------------------------------------
// lru_frame_replacement_order: LRU order over physical frames
// Keeps a recency order as a doubly linked list in next/previous link RAMs
// with head (most recent) and tail (least recent) registers. Touch moves a
// frame to the head; victim moves the tail to the head and reports it.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                      tuser
//  s_*      in   [6:0] frame_index          [0] command (0 touch, 1 victim)
//  m_*      out  [6:0] victim_frame         -
//
//  Steps: an order-changing request passes accept with link reads, unlink and
//  link in front of the head, set by one write port per link RAM; a touch of
//  the head or of a frame at or beyond FRAMES ends at accept.
//  Reset: a clearing pass over every frame loads the initial order; no request is
//  taken meanwhile. Stalls: a victim holds in its final step while the last
//  result still waits in the output register; m_tready blocks nothing else.
//
module lru_frame_replacement_order
  import lrufro_pkg::*;
#(
  parameter int FRAMES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [6:0] frame_index, [7] zero
  input  logic [0:0] s_tuser,   // [0] command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [6:0] victim_frame, [7] zero
);

  dp_cmd_t            cmd;
  dp_status_t         st;
  logic [FIELD_W-1:0] victim_frame;

  lrufro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lrufro_dp #(.FRAMES(FRAMES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .command      (s_tuser[0]),
    .frame_index  (s_tdata[FIELD_W-1:0]),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .victim_frame (victim_frame)
  );

  // pad the result to a whole byte
  assign m_tdata = {1'b0, victim_frame};

endmodule
